### rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, codes and constants of the differential drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // input item operation codes
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_LOAD_X    = 2'd1;
    localparam logic [1:0] OP_LOAD_Y    = 2'd2;
    localparam logic [1:0] OP_LOAD_HEAD = 2'd3;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_LEFT_GAIN     = 2'd0,
        REG_RIGHT_GAIN    = 2'd1,
        REG_INVERSE_TRACK = 2'd2,
        REG_SAMPLE_RATE   = 2'd3
    } cfg_idx_t;

    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

    // cordic start vector, reciprocal of the limit gain in q30
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

    // multiply jobs run on the shared multiply-accumulate unit
    typedef enum logic [2:0] {
        JOB_HEAD = 3'd0,
        JOB_XPOS = 3'd1,
        JOB_YPOS = 3'd2,
        JOB_LSPD = 3'd3,
        JOB_RSPD = 3'd4,
        JOB_ANG  = 3'd5
    } job_t;

    typedef struct packed {
        logic [31:0] left_gain;
        logic [31:0] right_gain;
        logic [31:0] inverse_track;
        logic [15:0] sample_rate;
    } ddo_cfg_t;

    typedef struct packed {
        logic accept;
        logic scale;
        logic sum;
        logic mac_load;
        logic mac_lo;
        logic mac_hi;
        logic mac_write;
        logic cordic_init;
        logic cordic_step;
        logic out_load;
        job_t job;
    } ddo_cmd_t;

    // arctangent of 2^-i as a binary angle
    function automatic logic [29:0] atan_lookup(input logic [4:0] idx);
        logic [29:0] r;
        unique case (idx)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            5'd24: r = 30'd41;
            5'd25: r = 30'd20;
            5'd26: r = 30'd10;
            5'd27: r = 30'd5;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            5'd30: r = 30'd1;
            5'd31: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/ddo_regs.sv
// ----------------------------------------------------------------------------
// ddo_regs
// APB-style configuration registers: gains, inverse track and sample rate.
// ----------------------------------------------------------------------------
module ddo_regs import ddo_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output ddo_cfg_t    cfg
);

    ddo_cfg_t cfg_reg;
    cfg_idx_t idx;

    assign idx = cfg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left_gain     <= 32'd65536;
            cfg_reg.right_gain    <= 32'd65536;
            cfg_reg.inverse_track <= 32'd65536;
            cfg_reg.sample_rate   <= 16'd100;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_LEFT_GAIN:     cfg_reg.left_gain     <= pwdata;
                REG_RIGHT_GAIN:    cfg_reg.right_gain    <= pwdata;
                REG_INVERSE_TRACK: cfg_reg.inverse_track <= pwdata;
                REG_SAMPLE_RATE:   cfg_reg.sample_rate   <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LEFT_GAIN:     prdata = cfg_reg.left_gain;
            REG_RIGHT_GAIN:    prdata = cfg_reg.right_gain;
            REG_INVERSE_TRACK: prdata = cfg_reg.inverse_track;
            REG_SAMPLE_RATE:   prdata = {16'd0, cfg_reg.sample_rate};
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### rtl/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer: steps the datapath through distance, multiply jobs and cordic.
// ----------------------------------------------------------------------------
module ddo_ctrl import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 24,
    parameter int IW = $clog2(CORDIC_STEPS)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic [1:0]    s_op,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output ddo_cmd_t      cmd,
    output logic [IW-1:0] iter
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIST, ST_SUM, ST_MLOAD, ST_MLO, ST_MHI, ST_MWRITE,
        ST_CINIT, ST_CORDIC, ST_OUT
    } state_t;

    state_t        state_reg;
    job_t          job_reg;
    logic [IW-1:0] iter_reg;
    logic          m_valid_reg;
    logic          out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            job_reg     <= JOB_HEAD;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !cmd.out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_op == OP_TICK) begin
                            job_reg   <= JOB_HEAD;
                            state_reg <= ST_DIST;
                        end else begin
                            job_reg   <= JOB_ANG;
                            state_reg <= ST_MLOAD;
                        end
                    end
                end
                ST_DIST:  state_reg <= ST_SUM;
                ST_SUM:   state_reg <= ST_MLOAD;
                ST_MLOAD: state_reg <= ST_MLO;
                ST_MLO:   state_reg <= ST_MHI;
                ST_MHI:   state_reg <= ST_MWRITE;
                ST_MWRITE: begin
                    unique case (job_reg)
                        JOB_HEAD: state_reg <= ST_CINIT;
                        JOB_XPOS: begin
                            job_reg   <= JOB_YPOS;
                            state_reg <= ST_MLOAD;
                        end
                        JOB_YPOS: begin
                            job_reg   <= JOB_LSPD;
                            state_reg <= ST_MLOAD;
                        end
                        JOB_LSPD: begin
                            job_reg   <= JOB_RSPD;
                            state_reg <= ST_MLOAD;
                        end
                        JOB_RSPD: begin
                            job_reg   <= JOB_ANG;
                            state_reg <= ST_MLOAD;
                        end
                        default:  state_reg <= ST_OUT;
                    endcase
                end
                ST_CINIT: begin
                    iter_reg  <= '0;
                    state_reg <= ST_CORDIC;
                end
                ST_CORDIC: begin
                    if (iter_reg == IW'(CORDIC_STEPS - 1)) begin
                        job_reg   <= JOB_XPOS;
                        state_reg <= ST_MLOAD;
                    end else begin
                        iter_reg <= iter_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd             = '0;
        cmd.job         = job_reg;
        cmd.accept      = (state_reg == ST_IDLE) && s_valid;
        cmd.scale       = (state_reg == ST_DIST);
        cmd.sum         = (state_reg == ST_SUM);
        cmd.mac_load    = (state_reg == ST_MLOAD);
        cmd.mac_lo      = (state_reg == ST_MLO);
        cmd.mac_hi      = (state_reg == ST_MHI);
        cmd.mac_write   = (state_reg == ST_MWRITE);
        cmd.cordic_init = (state_reg == ST_CINIT);
        cmd.cordic_step = (state_reg == ST_CORDIC);
        cmd.out_load    = (state_reg == ST_OUT) && out_free;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign iter    = iter_reg;

endmodule

### rtl/ddo_dp.sv
// ----------------------------------------------------------------------------
// ddo_dp
// Datapath: wheel distances, shared multiply-accumulate, cordic, pose state.
// ----------------------------------------------------------------------------
module ddo_dp import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 24,
    parameter int IW = $clog2(CORDIC_STEPS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ddo_cmd_t            cmd,
    input  logic [IW-1:0]       iter,
    input  ddo_cfg_t            cfg,
    input  logic [1:0]          s_op,
    input  logic signed [15:0]  s_left_count,
    input  logic signed [15:0]  s_right_count,
    input  logic signed [47:0]  s_load_value,
    output logic signed [47:0]  m_pos_x,
    output logic signed [47:0]  m_pos_y,
    output logic signed [31:0]  m_heading,
    output logic signed [47:0]  m_left_speed,
    output logic signed [47:0]  m_right_speed,
    output logic signed [47:0]  m_linear_speed,
    output logic signed [47:0]  m_angular_speed
);

    function automatic logic signed [47:0] sat49(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v[48] != v[47]) begin
            r = v[48] ? MIN48 : MAX48;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    // pose and speed state
    logic signed [47:0] x_reg, y_reg, lsr_reg, rsr_reg;
    logic        [31:0] head_reg;

    // per tick working values
    logic signed [15:0] lc_reg, rc_reg;
    logic signed [47:0] dl_reg, dr_reg, mean_reg, ang_reg;
    logic signed [48:0] diff_reg;

    // multiply-accumulate
    logic signed [48:0] mac_a_reg, mac_a_next;
    logic signed [32:0] mac_b_reg, mac_b_next;
    logic signed [81:0] acc_reg, acc_sh;
    logic signed [25:0] mul_a;
    logic signed [58:0] mul_p;
    logic signed [47:0] sat_val;
    logic               acc_ovf;

    // cordic
    logic signed [33:0] cx_reg, cy_reg, cx_sh, cy_sh, c_full, s_full;
    logic signed [32:0] cz_reg, atan_v;
    logic               flip_reg;

    logic signed [48:0] dl_prod, dr_prod, pair_sum, spd_sum, spd_diff;
    logic signed [48:0] mean_full, lin_full;

    assign dl_prod  = 49'(lc_reg) * 49'($signed({1'b0, cfg.left_gain}));
    assign dr_prod  = 49'(rc_reg) * 49'($signed({1'b0, cfg.right_gain}));
    assign pair_sum = {dl_reg[47], dl_reg} + {dr_reg[47], dr_reg};
    assign mean_full = (pair_sum + {48'd0, pair_sum[48]}) >>> 1;
    assign spd_sum  = {lsr_reg[47], lsr_reg} + {rsr_reg[47], rsr_reg};
    assign lin_full = (spd_sum + {48'd0, spd_sum[48]}) >>> 1;
    assign spd_diff = {lsr_reg[47], lsr_reg} - {rsr_reg[47], rsr_reg};

    assign c_full = flip_reg ? -cx_reg : cx_reg;
    assign s_full = flip_reg ? -cy_reg : cy_reg;

    // operand select per job
    always_comb begin
        unique case (cmd.job)
            JOB_HEAD: begin
                mac_a_next = diff_reg;
                mac_b_next = $signed({1'b0, cfg.inverse_track});
            end
            JOB_XPOS: begin
                mac_a_next = {mean_reg[47], mean_reg};
                mac_b_next = c_full[32:0];
            end
            JOB_YPOS: begin
                mac_a_next = {mean_reg[47], mean_reg};
                mac_b_next = s_full[32:0];
            end
            JOB_LSPD: begin
                mac_a_next = {dl_reg[47], dl_reg};
                mac_b_next = $signed({17'd0, cfg.sample_rate});
            end
            JOB_RSPD: begin
                mac_a_next = {dr_reg[47], dr_reg};
                mac_b_next = $signed({17'd0, cfg.sample_rate});
            end
            default: begin
                mac_a_next = spd_diff;
                mac_b_next = $signed({1'b0, cfg.inverse_track});
            end
        endcase
    end

    // one multiplier, low half then high half of operand a
    assign mul_a = cmd.mac_hi ? {{2{mac_a_reg[48]}}, mac_a_reg[48:25]}
                              : $signed({1'b0, mac_a_reg[24:0]});
    assign mul_p = 59'(mul_a) * 59'(mac_b_reg);

    always_comb begin
        unique case (cmd.job)
            JOB_XPOS, JOB_YPOS: acc_sh = acc_reg >>> 30;
            JOB_LSPD, JOB_RSPD: acc_sh = acc_reg;
            default:            acc_sh = acc_reg >>> 16;
        endcase
    end

    assign acc_ovf = !((&acc_sh[81:47]) || !(|acc_sh[81:47]));
    assign sat_val = acc_ovf ? (acc_sh[81] ? MIN48 : MAX48) : acc_sh[47:0];

    assign cx_sh  = cx_reg >>> iter;
    assign cy_sh  = cy_reg >>> iter;
    assign atan_v = $signed({3'd0, atan_lookup(5'(iter))});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg    <= '0;
            y_reg    <= '0;
            head_reg <= '0;
            lsr_reg  <= '0;
            rsr_reg  <= '0;
        end else begin
            if (cmd.accept) begin
                unique case (s_op)
                    OP_LOAD_X:    x_reg    <= s_load_value;
                    OP_LOAD_Y:    y_reg    <= s_load_value;
                    OP_LOAD_HEAD: head_reg <= s_load_value[31:0];
                    default:      ;
                endcase
            end
            if (cmd.mac_write) begin
                unique case (cmd.job)
                    JOB_HEAD: head_reg <= head_reg + acc_reg[47:16];
                    JOB_XPOS: x_reg    <= sat49({x_reg[47], x_reg} + {sat_val[47], sat_val});
                    JOB_YPOS: y_reg    <= sat49({y_reg[47], y_reg} + {sat_val[47], sat_val});
                    JOB_LSPD: lsr_reg  <= sat_val;
                    JOB_RSPD: rsr_reg  <= sat_val;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            lc_reg <= s_left_count;
            rc_reg <= s_right_count;
        end
        if (cmd.scale) begin
            dl_reg <= dl_prod[47:0];
            dr_reg <= dr_prod[47:0];
        end
        if (cmd.sum) begin
            mean_reg <= mean_full[47:0];
            diff_reg <= {dl_reg[47], dl_reg} - {dr_reg[47], dr_reg};
        end
        if (cmd.mac_load) begin
            mac_a_reg <= mac_a_next;
            mac_b_reg <= mac_b_next;
        end
        if (cmd.mac_lo) begin
            acc_reg <= {{23{mul_p[58]}}, mul_p};
        end
        if (cmd.mac_hi) begin
            acc_reg <= acc_reg + {mul_p[56:0], 25'd0};
        end
        if (cmd.mac_write && cmd.job == JOB_ANG) begin
            ang_reg <= sat_val;
        end
        if (cmd.cordic_init) begin
            // rotate by pi when the heading lies in the left half plane
            flip_reg <= head_reg[31] ^ head_reg[30];
            cz_reg   <= $signed({head_reg[30], head_reg[30], head_reg[30:0]});
            cx_reg   <= CORDIC_K;
            cy_reg   <= '0;
        end
        if (cmd.cordic_step) begin
            if (!cz_reg[32]) begin
                cx_reg <= cx_reg - cy_sh;
                cy_reg <= cy_reg + cx_sh;
                cz_reg <= cz_reg - atan_v;
            end else begin
                cx_reg <= cx_reg + cy_sh;
                cy_reg <= cy_reg - cx_sh;
                cz_reg <= cz_reg + atan_v;
            end
        end
        if (cmd.out_load) begin
            m_pos_x         <= x_reg;
            m_pos_y         <= y_reg;
            m_heading       <= head_reg;
            m_left_speed    <= lsr_reg;
            m_right_speed   <= rsr_reg;
            m_linear_speed  <= lin_full[47:0];
            m_angular_speed <= ang_reg;
        end
    end

endmodule

### rtl/differential_drive_odometry_top.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Differential drive wheel odometry: pose and speeds from encoder counts.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_*       in         s_valid / s_ready  op, left/right count, load value
//  m_*       out        m_valid / m_ready  pose, wheel, linear, angular speed
//  apb       in         psel/penable       four config registers at 4*i
//
//  a tick transfer runs the distance and sum steps, the heading job, the cordic
//  loop (one rotation per cycle) and the other five of six two-pass jobs on
//  the one shared multiply-accumulate unit; a load transfer runs only the angular speed job
//  one item is in work at a time; s_ready is high only while the sequencer
//  waits for an item
//  a finished result sits in the output register; the next item may start
//  meanwhile and waits at the end only if the previous result is still held
//  aresetn is synchronous, active low, clears pose and speeds and resets config to defaults
//
module differential_drive_odometry_top import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [15:0] s_left_count,
    input  logic signed [15:0] s_right_count,
    input  logic signed [47:0] s_load_value,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_pos_x,
    output logic signed [47:0] m_pos_y,
    output logic signed [31:0] m_heading,
    output logic signed [47:0] m_left_speed,
    output logic signed [47:0] m_right_speed,
    output logic signed [47:0] m_linear_speed,
    output logic signed [47:0] m_angular_speed,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // iteration counter width of the cordic loop
    localparam int IW = $clog2(CORDIC_STEPS);

    ddo_cfg_t      cfg;
    ddo_cmd_t      cmd;
    logic [IW-1:0] iter;

    // register writes always complete in the access cycle
    assign pready = 1'b1;

    ddo_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // sequencer: owns the handshakes and the cordic iteration count
    ddo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .IW           (IW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .iter    (iter)
    );

    // datapath: arithmetic, pose state and the output register
    ddo_dp #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .IW           (IW)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .iter            (iter),
        .cfg             (cfg),
        .s_op            (s_op),
        .s_left_count    (s_left_count),
        .s_right_count   (s_right_count),
        .s_load_value    (s_load_value),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_heading       (m_heading),
        .m_left_speed    (m_left_speed),
        .m_right_speed   (m_right_speed),
        .m_linear_speed  (m_linear_speed),
        .m_angular_speed (m_angular_speed)
    );

endmodule

### rtl/ddo_checker.sv
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks of the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module ddo_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               pready
);

    // a held result stays offered
    a_m_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // one item in work at a time
    a_ready_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

    // reset clears the result channel
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // the config port never stalls
    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

    // no result before any item was taken right after reset
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result without an item");

endmodule

bind differential_drive_odometry_top ddo_checker u_chk (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// odometry testbench
// Drives ticks and pose loads through the input channel, predicts pose and
// speeds with a behavioral odometry model and checks every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import ddo_pkg::*;

typedef struct {
    logic [47:0] px;
    logic [47:0] py;
    logic [31:0] hd;
    logic [47:0] ls;
    logic [47:0] rs;
    logic [47:0] lin;
    logic [47:0] angv;
} pose_t;

class odometry_scoreboard;
    // predicted state and configuration
    logic [31:0] lgain, rgain, itrack;
    logic [15:0] rate;
    longint xa, ya, lsp, rsp;
    logic [31:0] hacc;
    pose_t pending[$];
    int errors;

    function new();
        reset_state();
        errors = 0;
    endfunction

    function void reset_state();
        lgain = 65536; rgain = 65536; itrack = 65536; rate = 100;
        xa = 0; ya = 0; lsp = 0; rsp = 0; hacc = 0;
    endfunction

    function longint clamp48(longint v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return v;
    endfunction

    // floor(a*b / 2^s) saturated to 48 bits, using a wide product
    function longint scaled_product(longint a, longint b, int s);
        logic signed [127:0] p;
        p = 128'(signed'(a)) * 128'(signed'(b));
        p = p >>> s;
        if (p > 128'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (p < -128'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return longint'(p);
    endfunction

    function void rotate(logic [31:0] a, output longint c, output longint s);
        logic flip;
        longint x, y, z, nx;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip) a[31] = ~a[31];
        x = 652032874; y = 0;
        z = longint'(signed'(a));
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i);
                z -= longint'(atan_lookup(5'(i)));
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i);
                z += longint'(atan_lookup(5'(i)));
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] v);
        case (idx)
            REG_LEFT_GAIN:     lgain = v;
            REG_RIGHT_GAIN:    rgain = v;
            REG_INVERSE_TRACK: itrack = v;
            REG_SAMPLE_RATE:   rate = v[15:0];
        endcase
    endfunction

    function void note_input(logic [1:0] op, logic signed [15:0] lc,
                             logic signed [15:0] rc, logic signed [47:0] lv);
        longint dl, dr, mean, c, s, diff;
        logic [63:0] prod;
        pose_t r;
        case (op)
            OP_TICK: begin
                dl = longint'(lc) * longint'({32'd0, lgain});
                dr = longint'(rc) * longint'({32'd0, rgain});
                mean = (dl + dr) / 2;
                prod = 64'(dl - dr) * {32'd0, itrack};
                hacc = hacc + prod[47:16];
                rotate(hacc, c, s);
                xa = clamp48(xa + scaled_product(mean, c, 30));
                ya = clamp48(ya + scaled_product(mean, s, 30));
                lsp = clamp48(dl * longint'({48'd0, rate}));
                rsp = clamp48(dr * longint'({48'd0, rate}));
            end
            OP_LOAD_X: xa = longint'(lv);
            OP_LOAD_Y: ya = longint'(lv);
            default:   hacc = lv[31:0];
        endcase
        diff = lsp - rsp;
        r.px = xa[47:0]; r.py = ya[47:0]; r.hd = hacc;
        r.ls = lsp[47:0]; r.rs = rsp[47:0];
        r.lin = 48'((lsp + rsp) / 2);
        r.angv = 48'(scaled_product(diff, longint'({32'd0, itrack}), 16));
        pending.push_back(r);
    endfunction

    // one line per mismatch, counted
    task report(string msg);
        $display("mismatch %s", msg);
        errors++;
    endtask

    task field(string name, logic [47:0] got, logic [47:0] want);
        if (got !== want) begin
            report($sformatf("%s: got %h want %h", name, got, want));
        end
    endtask

    task check_result(pose_t g);
        pose_t e;
        if (pending.size() == 0) begin
            report("result transfer with nothing expected");
            return;
        end
        e = pending.pop_front();
        field("pos_x", g.px, e.px);
        field("pos_y", g.py, e.py);
        field("heading", {16'd0, g.hd}, {16'd0, e.hd});
        field("left_speed", g.ls, e.ls);
        field("right_speed", g.rs, e.rs);
        field("linear_speed", g.lin, e.lin);
        field("angular_speed", g.angv, e.angv);
    endtask
endclass

module testbench;
    logic aclk, aresetn;
    logic s_valid, s_ready;
    logic [1:0] s_op;
    logic signed [15:0] s_left_count, s_right_count;
    logic signed [47:0] s_load_value;
    logic m_valid, m_ready;
    logic signed [47:0] m_pos_x, m_pos_y, m_left_speed, m_right_speed;
    logic signed [47:0] m_linear_speed, m_angular_speed;
    logic signed [31:0] m_heading;
    logic psel, penable, pwrite, pready;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;

    odometry_scoreboard odo;
    int burst_left;
    bit stall_on;

    differential_drive_odometry_top dut (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // run limit: ~520 items plus stalls, taken many times over
    initial begin
        #4000000;
        $display("FAIL differential_drive_odometry_top");
        $finish;
    end

    // receiver stalls on a pattern of its own: long open stretches, then churn
    initial begin
        int cyc;
        cyc = 0;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if ((cyc / 400) % 3 == 0) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // results are checked at the rising edge of the transfer
    always @(posedge aclk) begin
        pose_t g;
        if (aresetn && m_valid && m_ready) begin
            g.px = m_pos_x; g.py = m_pos_y; g.hd = m_heading;
            g.ls = m_left_speed; g.rs = m_right_speed;
            g.lin = m_linear_speed; g.angv = m_angular_speed;
            odo.check_result(g);
        end
    end

    // apb write, setup cycle then access cycle
    task automatic reg_write(cfg_idx_t idx, logic [31:0] v);
        @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        odo.write_reg(idx, v);
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // close the current burst, wait for every expected result, then the
    // block's trailing cycles
    task automatic drain();
        s_valid <= 0;
        burst_left = 0;
        while (odo.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic send(logic [1:0] op, logic [15:0] lc, logic [15:0] rc,
                        logic [47:0] lv);
        // sender bursts with random gaps in between
        if (burst_left == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 40)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1; s_op <= op;
        s_left_count <= lc; s_right_count <= rc; s_load_value <= lv;
        do @(posedge aclk); while (!s_ready);
        odo.note_input(op, lc, rc, lv);
        @(negedge aclk);
        if (burst_left == 0) s_valid <= 0;
    endtask

    function automatic logic [15:0] rand_count();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    function automatic logic [47:0] rand_load();
        if ($urandom_range(0, 3) == 0) return 48'({$urandom, $urandom});
        return 48'($signed($urandom_range(0, 2000000)) - 1000000) <<< 16;
    endfunction

    task automatic random_phase(int n);
        int k;
        logic [1:0] op;
        for (k = 0; k < n; k++) begin
            op = ($urandom_range(0, 9) < 7) ? OP_TICK : 2'($urandom_range(1, 3));
            send(op, rand_count(), rand_count(), rand_load());
        end
        drain();
    endtask

    initial begin
        odo = new();
        burst_left = 0;
        aresetn = 0; s_valid = 0; s_op = OP_TICK;
        s_left_count = 0; s_right_count = 0; s_load_value = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: reset settings, extreme counts, every op, loads
        send(OP_TICK, 16'd0, 16'd0, 48'd0);
        send(OP_TICK, 16'd100, 16'd100, 48'd0);
        send(OP_TICK, 16'd100, -16'sd100, 48'd0);
        send(OP_TICK, 16'h7FFF, 16'h8000, 48'd0);
        send(OP_TICK, 16'h8000, 16'h8000, 48'd0);
        send(OP_LOAD_X, 16'hFFFF, 16'hFFFF, 48'h7FFF_FFFF_FFFF);
        send(OP_LOAD_Y, 16'd0, 16'd0, 48'h8000_0000_0000);
        send(OP_TICK, 16'h7FFF, 16'h7FFF, 48'd0);
        // heading load ignores upper bits; quadrant edges of the rotation
        send(OP_LOAD_HEAD, 16'd0, 16'd0, 48'hABCD_4000_0000);
        send(OP_TICK, 16'd10, 16'd10, 48'd0);
        send(OP_LOAD_HEAD, 16'd0, 16'd0, 48'h0000_8000_0000);
        send(OP_TICK, 16'd10, 16'd10, 48'd0);
        send(OP_LOAD_HEAD, 16'd0, 16'd0, 48'hFFFF_C000_0000);
        send(OP_TICK, 16'd10, 16'd10, 48'd0);
        send(OP_LOAD_X, 16'd0, 16'd0, 48'd0);
        send(OP_LOAD_Y, 16'd0, 16'd0, 48'd0);
        // sender holds off until everything has come back
        drain();

        // extreme gains, sample rate at the top, saturating speeds
        reg_write(REG_LEFT_GAIN, 32'hFFFF_FFFF);
        reg_write(REG_RIGHT_GAIN, 32'hFFFF_FFFF);
        reg_write(REG_INVERSE_TRACK, 32'hFFFF_FFFF);
        reg_write(REG_SAMPLE_RATE, 32'h0000_FFFF);
        send(OP_TICK, 16'h7FFF, 16'h8000, 48'd0);
        send(OP_TICK, 16'h8000, 16'h7FFF, 48'd0);
        random_phase(60);

        // zero gains and zero sample rate: speeds go to zero
        reg_write(REG_LEFT_GAIN, 32'd0);
        reg_write(REG_RIGHT_GAIN, 32'd0);
        reg_write(REG_INVERSE_TRACK, 32'd0);
        reg_write(REG_SAMPLE_RATE, 32'd0);
        random_phase(40);

        // minimum sample rate, then a few random settings
        reg_write(REG_SAMPLE_RATE, 32'd1);
        reg_write(REG_LEFT_GAIN, 32'd65536);
        reg_write(REG_RIGHT_GAIN, 32'd70000);
        reg_write(REG_INVERSE_TRACK, 32'd300);
        random_phase(100);
        repeat (3) begin
            reg_write(REG_LEFT_GAIN, $urandom);
            reg_write(REG_RIGHT_GAIN, $urandom_range(0, 1 << 20));
            reg_write(REG_INVERSE_TRACK, $urandom_range(0, 1 << 18));
            reg_write(REG_SAMPLE_RATE, $urandom_range(1, 65535));
            random_phase(100);
        end

        if (odo.errors == 0 && odo.pending.size() == 0) begin
            $display("PASS differential_drive_odometry_top");
        end else begin
            $display("FAIL differential_drive_odometry_top");
        end
        $finish;
    end
endmodule
